FILE: rtl/pfa_pkg.sv
// shared constants, codes and types of the page frame allocator
`default_nettype none
package pfa_pkg;

    localparam int PAGE_COUNT = 65536;
    localparam int PAGE_W     = 16;
    localparam int ADDR_W     = $clog2(PAGE_COUNT);
    localparam int TOP_W      = ADDR_W + 1;
    localparam int REF_WIDTH  = 8;

    localparam logic [REF_WIDTH-1:0] REF_MAX = '1;

    localparam logic CFG_FIRST_PAGE = 1'b0;
    localparam logic CFG_LIMIT_PAGE = 1'b1;

    localparam logic [2:0] ACT_ALLOC   = 3'd0;
    localparam logic [2:0] ACT_FREE    = 3'd1;
    localparam logic [2:0] ACT_INC     = 3'd2;
    localparam logic [2:0] ACT_DEC     = 3'd3;
    localparam logic [2:0] ACT_INSPECT = 3'd4;

    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_NO_FREE  = 3'd1;
    localparam logic [2:0] STS_BAD_FREE = 3'd2;
    localparam logic [2:0] STS_RANGE    = 3'd3;
    localparam logic [2:0] STS_FULL     = 3'd4;

    typedef struct packed {
        logic                 rd_en;
        logic [ADDR_W-1:0]    rd_addr;
        logic                 wr_en;
        logic [ADDR_W-1:0]    wr_addr;
        logic [REF_WIDTH-1:0] wr_data;
    } rt_req_t;

endpackage
`default_nettype wire

FILE: rtl/pfa_ref_table.sv
// reference count memory with clearing sweep after reset
`default_nettype none
module pfa_ref_table (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire pfa_pkg::rt_req_t               req,
    output logic [pfa_pkg::REF_WIDTH-1:0]       rd_data,
    output logic                                busy
);

    logic [pfa_pkg::REF_WIDTH-1:0] mem [pfa_pkg::PAGE_COUNT];

    logic                         busy_reg;
    logic                         busy_next;
    logic [pfa_pkg::ADDR_W-1:0]   clr_addr_reg;
    logic [pfa_pkg::ADDR_W-1:0]   clr_addr_next;
    logic [pfa_pkg::REF_WIDTH-1:0] rd_data_reg;

    logic                          wr_en;
    logic [pfa_pkg::ADDR_W-1:0]    wr_addr;
    logic [pfa_pkg::REF_WIDTH-1:0] wr_data;

    always_comb
    begin
        busy_next     = busy_reg;
        clr_addr_next = clr_addr_reg;
        if (busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (&clr_addr_reg)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (busy_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = req.wr_en;
            wr_addr = req.wr_addr;
            wr_data = req.wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            busy_reg     <= busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule
`default_nettype wire

FILE: rtl/page_frame_allocator_refcount.sv
// top level: free page stack, reference counts and request sequencer
// sequence: alloc goes through ST_POP (stack read), ST_READ (count read and write) and
// ST_DONE, other actions skip ST_POP, an empty-stack alloc goes straight to ST_DONE
// one transaction at a time, paced by the dependent reads of the stack memory and
// the count memory
// a full result waits in the output register while the next transaction is taken
// after reset the count memory is swept to zero with in_ready low;
// configuration writes are taken during the sweep
`default_nettype none
module page_frame_allocator_refcount (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [16:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  action,
    input  wire logic [15:0] page,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      result_page,
    output logic [2:0]       status,
    output logic [7:0]       ref_count,
    output logic [16:0]      free_count,
    output logic             page_released
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_POP  = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [2:0]  action_reg, action_next;
    logic [15:0] page_reg, page_next;
    logic [pfa_pkg::TOP_W-1:0] top_reg, top_next;
    logic [15:0] first_reg;
    logic [16:0] limit_reg;

    logic [15:0] res_page_reg, res_page_next;
    logic [2:0]  res_status_reg, res_status_next;
    logic [7:0]  res_count_reg, res_count_next;
    logic        res_rel_reg, res_rel_next;

    logic        out_valid_reg;
    logic [15:0] out_page_reg;
    logic [2:0]  out_status_reg;
    logic [7:0]  out_count_reg;
    logic [16:0] out_free_reg;
    logic        out_rel_reg;
    logic        out_load;

    logic [15:0] stk_mem [pfa_pkg::PAGE_COUNT];
    logic                       stk_rd_en;
    logic [pfa_pkg::ADDR_W-1:0] stk_rd_addr;
    logic [15:0]                stk_rd_data_reg;
    logic                       stk_wr_en;

    pfa_pkg::rt_req_t              rt_req;
    logic [pfa_pkg::REF_WIDTH-1:0] rt_rd_data;
    logic                          rt_busy;

    logic                          accept;
    logic                          in_table;
    logic [pfa_pkg::TOP_W-1:0]     top_dec;
    logic [pfa_pkg::REF_WIDTH-1:0] cnt_inc;
    logic [pfa_pkg::REF_WIDTH-1:0] cnt_dec;
    logic                          free_ok;

    pfa_ref_table u_ref_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (rt_req),
        .rd_data (rt_rd_data),
        .busy    (rt_busy)
    );

    assign in_ready = (state_reg == ST_IDLE) && !rt_busy;
    assign accept   = in_valid && in_ready;
    assign in_table = {16'd0, page} < 32'(pfa_pkg::PAGE_COUNT);
    assign top_dec  = top_reg - 1'b1;
    assign cnt_inc  = (rt_rd_data == pfa_pkg::REF_MAX) ? rt_rd_data : rt_rd_data + 1'b1;
    assign cnt_dec  = (rt_rd_data == '0) ? rt_rd_data : rt_rd_data - 1'b1;
    assign free_ok  = (page_reg >= first_reg) && ({1'b0, page_reg} < limit_reg);
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next      = state_reg;
        action_next     = action_reg;
        page_next       = page_reg;
        top_next        = top_reg;
        res_page_next   = res_page_reg;
        res_status_next = res_status_reg;
        res_count_next  = res_count_reg;
        res_rel_next    = res_rel_reg;
        stk_rd_en       = 1'b0;
        stk_rd_addr     = top_dec[pfa_pkg::ADDR_W-1:0];
        stk_wr_en       = 1'b0;
        rt_req          = '0;
        rt_req.rd_addr  = page[pfa_pkg::ADDR_W-1:0];
        rt_req.wr_addr  = page_reg[pfa_pkg::ADDR_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    action_next     = action;
                    page_next       = page;
                    res_page_next   = page;
                    res_count_next  = '0;
                    res_rel_next    = 1'b0;
                    if (action == pfa_pkg::ACT_ALLOC)
                    begin
                        if (top_reg == '0)
                        begin
                            res_page_next   = '0;
                            res_status_next = pfa_pkg::STS_NO_FREE;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            top_next   = top_dec;
                            stk_rd_en  = 1'b1;
                            state_next = ST_POP;
                        end
                    end
                    else if (!in_table)
                    begin
                        res_status_next = (action == pfa_pkg::ACT_FREE) ?
                                          pfa_pkg::STS_BAD_FREE : pfa_pkg::STS_RANGE;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        rt_req.rd_en = 1'b1;
                        state_next   = ST_READ;
                    end
                end
            end

            ST_POP:
            begin
                page_next      = stk_rd_data_reg;
                rt_req.rd_en   = 1'b1;
                rt_req.rd_addr = stk_rd_data_reg[pfa_pkg::ADDR_W-1:0];
                state_next     = ST_READ;
            end

            ST_READ:
            begin
                res_page_next   = page_reg;
                res_status_next = pfa_pkg::STS_OK;
                res_count_next  = rt_rd_data;
                res_rel_next    = 1'b0;
                state_next      = ST_DONE;
                case (action_reg)
                    pfa_pkg::ACT_ALLOC, pfa_pkg::ACT_INC:
                    begin
                        rt_req.wr_en   = 1'b1;
                        rt_req.wr_data = cnt_inc;
                        res_count_next = cnt_inc;
                    end
                    pfa_pkg::ACT_DEC:
                    begin
                        rt_req.wr_en   = 1'b1;
                        rt_req.wr_data = cnt_dec;
                        res_count_next = cnt_dec;
                    end
                    pfa_pkg::ACT_FREE:
                    begin
                        if (!free_ok)
                        begin
                            res_status_next = pfa_pkg::STS_BAD_FREE;
                        end
                        else
                        begin
                            rt_req.wr_en   = 1'b1;
                            rt_req.wr_data = cnt_dec;
                            res_count_next = cnt_dec;
                            if (cnt_dec == '0)
                            begin
                                if (32'(top_reg) >= pfa_pkg::PAGE_COUNT)
                                begin
                                    res_status_next = pfa_pkg::STS_FULL;
                                end
                                else
                                begin
                                    stk_wr_en    = 1'b1;
                                    top_next     = top_reg + 1'b1;
                                    res_rel_next = 1'b1;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        res_count_next = rt_rd_data;
                    end
                endcase
            end

            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stk_wr_en)
        begin
            stk_mem[top_reg[pfa_pkg::ADDR_W-1:0]] <= page_reg;
        end
        if (stk_rd_en)
        begin
            stk_rd_data_reg <= stk_mem[stk_rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            top_reg       <= '0;
            first_reg     <= '0;
            limit_reg     <= 17'h10000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            top_reg   <= top_next;
            if (cfg_wr_en)
            begin
                if (cfg_index == pfa_pkg::CFG_FIRST_PAGE)
                begin
                    first_reg <= cfg_data[15:0];
                end
                else
                begin
                    limit_reg <= cfg_data;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        page_reg       <= page_next;
        res_page_reg   <= res_page_next;
        res_status_reg <= res_status_next;
        res_count_reg  <= res_count_next;
        res_rel_reg    <= res_rel_next;
        if (out_load)
        begin
            out_page_reg   <= res_page_reg;
            out_status_reg <= res_status_reg;
            out_count_reg  <= res_count_reg;
            out_free_reg   <= top_reg;
            out_rel_reg    <= res_rel_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_page   = out_page_reg;
    assign status        = out_status_reg;
    assign ref_count     = out_count_reg;
    assign free_count    = out_free_reg;
    assign page_released = out_rel_reg;

endmodule
`default_nettype wire
